>>> src/lfa_pkg.sv
// Shared types and codes for the lowest-free ID bitmap allocator.
package lfa_pkg;

    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    // request kinds
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_NOTALLOC = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;    // input beat taken, start first word read
        logic step;    // read next word
        logic commit;  // write back word, load result register
    } lfa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_more;  // allocate scan must look at the next word
        logic out_free;   // result register can take a new beat
    } lfa_stat_t;

endpackage

>>> src/lfa_ram.sv
// Generic single write port RAM with registered read.
module lfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/lfa_datapath.sv
// Datapath: bitmap words, lowest-free search, release check, result register.
module lfa_datapath #(
    parameter int ID_COUNT = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lfa_pkg::lfa_cmd_t cmd,
    output lfa_pkg::lfa_stat_t stat,
    input  logic              s_op,
    input  logic [7:0]        s_release_id,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [6:0]        m_granted_id,
    output logic [1:0]        m_status
);

    localparam int WORD_COUNT = (ID_COUNT + 31) / 32;
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int TAIL       = ID_COUNT % 32;
    localparam logic [31:0] LAST_MASK = (TAIL == 0) ? 32'hFFFF_FFFF
                                                    : 32'((64'd1 << TAIL) - 64'd1);

    logic                  op_reg;
    logic [7:0]            rel_id_reg;
    logic [AW-1:0]         chk_addr_reg, chk_addr_next;
    logic [WORD_COUNT-1:0] valid_reg, valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic [6:0]            gid_reg;
    logic [1:0]            st_reg;

    logic          rel_range_err;
    logic [15:0]   rel_word_w;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic [31:0]   ram_rdata;
    logic [31:0]   word;
    logic          last_word;
    logic [31:0]   avail;
    logic          found;
    logic [lfa_pkg::BIT_W-1:0] free_bit;
    logic [lfa_pkg::BIT_W-1:0] rel_bit;
    logic          rel_set;
    logic          range_q;
    logic          wr_en;
    logic [31:0]   wr_data;
    logic [15:0]   id_w;

    // release ID checks on the incoming beat
    assign rel_range_err = ({24'd0, s_release_id} >= 32'(ID_COUNT));
    assign rel_word_w    = 16'(s_release_id >> lfa_pkg::BIT_W);

    always_comb begin
        if (cmd.load) begin
            rd_addr = (s_op == lfa_pkg::OP_RELEASE && !rel_range_err)
                      ? rel_word_w[AW-1:0] : '0;
        end else begin
            rd_addr = chk_addr_reg + AW'(1);
        end
    end
    assign rd_en = cmd.load || cmd.step;
    assign chk_addr_next = rd_en ? rd_addr : chk_addr_reg;

    lfa_ram #(
        .WIDTH (32),
        .DEPTH (WORD_COUNT)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (chk_addr_reg),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // never-written words read as all free
    assign word      = valid_reg[chk_addr_reg] ? ram_rdata : '0;
    assign last_word = (chk_addr_reg == AW'(WORD_COUNT - 1));
    assign avail     = ~word & (last_word ? LAST_MASK : 32'hFFFF_FFFF);

    // lowest set bit of avail
    always_comb begin
        free_bit = '0;
        for (int i = 31; i >= 0; i--) begin
            if (avail[i]) begin
                free_bit = lfa_pkg::BIT_W'(i);
            end
        end
    end
    assign found = |avail;

    assign rel_bit = rel_id_reg[lfa_pkg::BIT_W-1:0];
    assign rel_set = word[rel_bit];
    assign range_q = ({24'd0, rel_id_reg} >= 32'(ID_COUNT));

    always_comb begin
        wr_en   = 1'b0;
        wr_data = word;
        if (op_reg == lfa_pkg::OP_ALLOC) begin
            wr_data = word | (32'd1 << free_bit);
            wr_en   = cmd.commit && found;
        end else begin
            wr_data = word & ~(32'd1 << rel_bit);
            wr_en   = cmd.commit && !range_q && rel_set;
        end
    end

    assign id_w = (16'(chk_addr_reg) << lfa_pkg::BIT_W) | 16'(free_bit);

    always_comb begin
        valid_next = valid_reg;
        if (wr_en) begin
            valid_next[chk_addr_reg] = 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_addr_reg <= chk_addr_next;
        if (cmd.load) begin
            op_reg     <= s_op;
            rel_id_reg <= s_release_id;
        end
        if (cmd.commit) begin
            if (op_reg == lfa_pkg::OP_ALLOC) begin
                gid_reg <= found ? id_w[6:0] : 7'd0;
                st_reg  <= found ? lfa_pkg::ST_OK : lfa_pkg::ST_FULL;
            end else begin
                gid_reg <= 7'd0;
                if (range_q) begin
                    st_reg <= lfa_pkg::ST_RANGE;
                end else if (!rel_set) begin
                    st_reg <= lfa_pkg::ST_NOTALLOC;
                end else begin
                    st_reg <= lfa_pkg::ST_OK;
                end
            end
        end
    end

    assign stat.need_more = (op_reg == lfa_pkg::OP_ALLOC) && !found && !last_word;
    assign stat.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid     = out_valid_reg;
    assign m_granted_id = gid_reg;
    assign m_status     = st_reg;

endmodule

>>> src/lfa_ctrl.sv
// Controller: takes one request, steps the word scan, commits the result.
module lfa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  lfa_pkg::lfa_stat_t stat,
    output lfa_pkg::lfa_cmd_t  cmd
);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_CHECK = 1'b1;

    logic state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.need_more) begin
                    cmd.step = 1'b1;
                end else if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/lowest_free_id_bitmap_allocator_core.sv
// Top level of the lowest-free ID bitmap allocator.
// Usage:
//   Slave channel carries one request per beat: s_tuser is the request kind
//   (0 allocate, 1 release), s_tdata is the ID to release (ignored for
//   allocate). Master channel returns exactly one beat per request:
//   m_tdata[6:0] is the granted ID (0 unless an allocate succeeded),
//   m_tuser is the status (0 ok, 1 full, 2 out of range, 3 not allocated).
// Bitmap and scan:
//   The bitmap lives in a RAM of 32-bit words with a registered read port.
//   A release reads one word. An allocate reads words in order, one per cycle,
//   and stops at the first word with a free bit or at the last word, so it
//   looks at 1 .. ID_COUNT/32 rounded up words (1 .. 4 words at 128 IDs).
// Throughput:
//   One request at a time; s_tready returns the cycle after the result is
//   loaded into the output register, so a new request overlaps a waiting one.
// Reset / stall:
//   aresetn (synchronous, active low) clears the per-word valid bits, so every
//   ID reads free with no clearing pass; an output beat in flight is dropped.
//   With m_tready low the result holds and the next request waits in check.
module lowest_free_id_bitmap_allocator_core #(
    parameter int ID_COUNT = 128
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] release_id
    input  logic       s_tuser,   // [0] op
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] granted_id, [7] zero pad
    output logic [1:0] m_tuser    // [1:0] status
);

    lfa_pkg::lfa_cmd_t  cmd;
    lfa_pkg::lfa_stat_t stat;
    logic [6:0]         granted_id;

    lfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lfa_datapath #(
        .ID_COUNT (ID_COUNT)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_op         (s_tuser),
        .s_release_id (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_granted_id (granted_id),
        .m_status     (m_tuser)
    );

    assign m_tdata = {1'b0, granted_id};

endmodule

>>> src/lfa_checker.sv
// Port-level checker for the allocator core, with its bind.
module lfa_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    logic [1:0] pending_reg, pending_next;
    logic       s_beat, m_beat;

    assign s_beat = s_tvalid && s_tready;
    assign m_beat = m_tvalid && m_tready;

    always_comb begin
        pending_next = pending_reg;
        if (s_beat && !m_beat) begin
            pending_next = pending_reg + 2'd1;
        end else if (!s_beat && m_beat) begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 2'd0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // no result without an outstanding request
    a_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != 2'd0)
        else $error("result beat without request");

    // at most one request in the core plus one result waiting
    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg != 2'd3)
        else $error("too many requests outstanding");

    // only a result with ok status may carry a nonzero ID
    a_gid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != lfa_pkg::ST_OK |-> m_tdata == 8'd0)
        else $error("nonzero ID on failed request");

endmodule

bind lowest_free_id_bitmap_allocator_core lfa_checker u_lfa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> dv/tb_lowest_free_id_bitmap_allocator_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the lowest-free ID bitmap allocator core.
module tb_lowest_free_id_bitmap_allocator_core;

    localparam int ID_COUNT       = 128;
    localparam int WORDS          = (ID_COUNT + lfa_pkg::WORD_BITS - 1) / lfa_pkg::WORD_BITS;
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with work pending but no beat
    localparam int TAIL_CYCLES    = 10;

    // one request as it goes onto the slave channel
    typedef struct packed {
        logic       op;
        logic [7:0] rid;
    } id_req_t;

    // one result as it should come off the master channel
    typedef struct packed {
        logic [6:0] id;
        logic [1:0] st;
    } id_result_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;   // [7:0] release_id
    logic       s_tuser  = 1'b0;   // [0] op
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [6:0] granted_id, [7] zero pad
    logic [1:0] m_tuser;           // [1:0] status

    id_req_t    pending_reqs[$];
    id_result_t expected_grants[$];

    // predictor's copy of the used/free bitmap, a set bit is a used ID
    bit [lfa_pkg::WORD_BITS-1:0] used_map[WORDS];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asks      = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    lowest_free_id_bitmap_allocator_core #(
        .ID_COUNT(ID_COUNT)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one request to the predicted bitmap and return the result it gives.
    // Allocate takes the lowest clear bit, release frees a used in-range ID.
    function automatic id_result_t allocate_or_release(id_req_t r);
        id_result_t res;
        int         w;
        int         b;
        res.id = 7'd0;
        res.st = lfa_pkg::ST_FULL;
        if (r.op == lfa_pkg::OP_ALLOC) begin
            for (int n = 0; n < ID_COUNT; n++) begin
                w = n / lfa_pkg::WORD_BITS;
                b = n % lfa_pkg::WORD_BITS;
                if (!used_map[w][b]) begin
                    used_map[w][b] = 1'b1;
                    res.id = n[6:0];
                    res.st = lfa_pkg::ST_OK;
                    return res;
                end
            end
            return res;   // no free ID left: full, bitmap unchanged
        end
        if (r.rid >= ID_COUNT) begin
            res.st = lfa_pkg::ST_RANGE;   // ID_COUNT itself is out of range too
            return res;
        end
        w = r.rid / lfa_pkg::WORD_BITS;
        b = r.rid % lfa_pkg::WORD_BITS;
        if (!used_map[w][b]) begin
            res.st = lfa_pkg::ST_NOTALLOC;
            return res;
        end
        used_map[w][b] = 1'b0;
        res.st = lfa_pkg::ST_OK;
        return res;
    endfunction

    // Driver: predict on each accepted beat, then offer the next pending
    // request unless this cycle is picked as a sender gap.
    always @(posedge aclk) begin : feed
        id_req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_grants.push_back(allocate_or_release({s_tuser, s_tdata}));
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.rid;
                    s_tuser  <= nxt.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: random stalls, plus a long hold-off on request so the
    // core backs up and drops s_tready while the driver keeps offering.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else if (hold_served != hold_asks) begin
            hold_served <= hold_asks;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: every result beat against the oldest expectation.
    always @(posedge aclk) begin : check
        id_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_grants.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result beat: tdata=%h tuser=%0d", m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                exp_res = expected_grants.pop_front();
                if (m_tdata !== {1'b0, exp_res.id} || m_tuser !== exp_res.st) begin
                    if (mismatch_count < 10)
                        $display("result mismatch: id exp %0d got %0d, status exp %0d got %0d",
                                 exp_res.id, m_tdata, exp_res.st, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: only counts while work is outstanding.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (pending_reqs.size() != 0 || expected_grants.size() != 0 || s_tvalid)
                quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_lowest_free_id_bitmap_allocator_core: errors");
            $finish;
        end
    end

    task automatic queue_one(logic op, logic [7:0] rid);
        id_req_t r;
        r.op  = op;
        r.rid = rid;
        pending_reqs.push_back(r);
    endtask

    // Random requests; alloc_pct sets how hard the bitmap is pushed toward full.
    task automatic queue_random(int n, int alloc_pct);
        int         pick;
        logic [7:0] rid;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 8)
                rid = 8'($urandom_range(255, ID_COUNT));
            else if (pick < 11)
                rid = 8'(ID_COUNT);
            else
                rid = 8'($urandom_range(ID_COUNT - 1));
            if ($urandom_range(99) < alloc_pct)
                queue_one(lfa_pkg::OP_ALLOC, 8'($urandom_range(255)));  // rid ignored
            else
                queue_one(lfa_pkg::OP_RELEASE, rid);
        end
    endtask

    // Sender pause: hold back until every request has produced its result.
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_grants.size() != 0 || s_tvalid)
            @(negedge aclk);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        @(negedge aclk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty-bitmap releases, range edges, lowest-free reuse
        queue_one(lfa_pkg::OP_RELEASE, 8'd0);
        queue_one(lfa_pkg::OP_RELEASE, 8'd127);
        queue_one(lfa_pkg::OP_RELEASE, 8'd128);
        queue_one(lfa_pkg::OP_RELEASE, 8'd255);
        queue_one(lfa_pkg::OP_ALLOC,   8'd0);
        queue_one(lfa_pkg::OP_ALLOC,   8'd255);
        queue_one(lfa_pkg::OP_ALLOC,   8'd0);
        queue_one(lfa_pkg::OP_RELEASE, 8'd1);
        queue_one(lfa_pkg::OP_RELEASE, 8'd1);
        queue_one(lfa_pkg::OP_ALLOC,   8'd0);
        queue_one(lfa_pkg::OP_RELEASE, 8'd0);
        queue_one(lfa_pkg::OP_RELEASE, 8'd2);
        queue_one(lfa_pkg::OP_ALLOC,   8'd0);
        queue_one(lfa_pkg::OP_ALLOC,   8'd0);
        wait_drained();

        // no idling: fill the bitmap across all words, then hit full
        for (int i = 0; i < ID_COUNT + 7; i++)
            queue_one(lfa_pkg::OP_ALLOC, 8'($urandom_range(255)));
        queue_random(30, 85);
        wait_drained();

        // sender gaps, release-heavy so the bitmap drains
        set_idling(47, 0);
        queue_random(160, 25);
        wait_drained();

        // receiver stalls, with one long hold-off while requests queue up
        set_idling(0, 47);
        queue_random(160, 70);
        hold_asks = hold_asks + 1;
        wait_drained();

        // both sides idling
        set_idling(11, 11);
        queue_random(160, 50);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_grants.size() == 0)
            $display("tb_lowest_free_id_bitmap_allocator_core: clean");
        else
            $display("tb_lowest_free_id_bitmap_allocator_core: errors");
        $finish;
    end

endmodule

>>> files.f
src/lfa_pkg.sv
src/lfa_ram.sv
src/lfa_datapath.sv
src/lfa_ctrl.sv
src/lowest_free_id_bitmap_allocator_core.sv
src/lfa_checker.sv
dv/tb_lowest_free_id_bitmap_allocator_core.sv
